>>> rtl/umrc_pkg.sv
// Shared types and constants for the UDP match, rewrite and checksum block.
// Holds the payload structs, the config bundle and the header and mode codes.
// No dependencies.
package umrc_pkg;

  // Header codes and limits
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IP_IHL_PLAIN  = 4'd5;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd42;

  // Mode register codes
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_PASS     = 3'd1;
  localparam logic [2:0] MODE_DROP     = 3'd2;
  localparam logic [2:0] MODE_RW_PORT  = 3'd3;
  localparam logic [2:0] MODE_REDIRECT = 3'd4;

  // Verdict codes
  localparam logic [1:0] VERDICT_PASS     = 2'd0;
  localparam logic [1:0] VERDICT_DROP     = 2'd1;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

  // Function codes
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Statistics counter indexes
  localparam int NUM_COUNTERS = 5;
  localparam logic [2:0] CNT_MATCHED  = 3'd0;
  localparam logic [2:0] CNT_BYTES    = 3'd1;
  localparam logic [2:0] CNT_REDIRECT = 3'd2;
  localparam logic [2:0] CNT_PASS     = 3'd3;
  localparam logic [2:0] CNT_DROP     = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_COLLECT    = 3'd1;
  localparam logic [2:0] REG_MATCH_IP   = 3'd2;
  localparam logic [2:0] REG_MATCH_PORT = 3'd3;
  localparam logic [2:0] REG_NEW_IP     = 3'd4;
  localparam logic [2:0] REG_NEW_PORT   = 3'd5;
  localparam logic [2:0] REG_NEW_TTL    = 3'd6;

  localparam int ADDR_BITS = 5;

  // Checksum accumulator: up to seven 16-bit terms
  localparam int ACC_BITS = 19;

  typedef struct packed {
    logic        func;
    logic [15:0] pkt_len;
    logic [15:0] ethertype;
    logic [3:0]  ip_hdr_words;
    logic [7:0]  ip_proto;
    logic [7:0]  ip_ttl;
    logic [31:0] dest_ip;
    logic [15:0] ip_sum;
    logic [15:0] dest_port;
    logic [15:0] udp_sum;
    logic [2:0]  counter_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        matched;
    logic [31:0] out_ip;
    logic [15:0] out_port;
    logic [7:0]  out_ttl;
    logic [15:0] out_ip_sum;
    logic [15:0] out_udp_sum;
    logic [63:0] counter_value;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        stats_en;
    logic [31:0] match_ip;
    logic [15:0] match_port;
    logic [31:0] new_ip;
    logic [15:0] new_port;
    logic [7:0]  new_ttl;
  } cfg_t;

  typedef struct packed {
    logic matched;
    logic redirect;
    logic pass;
    logic drop;
  } inc_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                rd;
    logic [2:0]          cidx;
    logic [1:0]          verdict;
    logic                matched;
    logic [31:0]         out_ip;
    logic [15:0]         out_port;
    logic [7:0]          out_ttl;
    logic [ACC_BITS-1:0] ip_acc;
    logic [ACC_BITS-1:0] udp_acc;
    logic                udp_map;
    logic [15:0]         pkt_len;
    inc_t                inc;
  } cls_t;

endpackage

>>> rtl/umrc_fifo.sv
// Two-entry register queue with queue-style handshake on both sides.
// Payload type is a module parameter; no package dependency.
module umrc_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  logic [1:0] count;
  logic [1:0] count_mid;
  logic       do_push;
  logic       do_pop;
  T           head;
  T           tail;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign count_mid = count - {1'b0, do_pop};
  assign dout    = head;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_mid + {1'b0, do_push};
    end
  end

  // Write into the first free slot after the pop, else shift on pop
  always_ff @(posedge clk) begin
    if (do_push && (count_mid == 2'd0)) begin
      head <= din;
    end else if (do_pop) begin
      head <= tail;
    end
    if (do_push && (count_mid != 2'd0)) begin
      tail <= din;
    end
  end

endmodule

>>> rtl/umrc_front.sv
// Front end: qualifies and matches one header, picks the action and
// gathers the checksum terms. Depends on umrc_pkg.
module umrc_front
  import umrc_pkg::*;
(
  input  in_item_t item,
  input  cfg_t     cfg,
  output cls_t     cls
);

  logic        qual;
  logic        ip_ok;
  logic        port_ok;
  logic        rw_ip;
  logic        rw_port;
  logic        rw_ttl;
  logic        udp_add;
  logic        stats;
  logic [15:0] ndip_hi;
  logic [15:0] ndip_lo;
  logic [15:0] nisum;
  logic [15:0] nusum;
  logic [15:0] nport;
  logic [15:0] nttl_word;
  logic [15:0] ttl_word;
  logic [ACC_BITS-1:0] ip32_terms;
  logic [ACC_BITS-1:0] ttl_terms;
  logic [ACC_BITS-1:0] port_terms;

  // Qualify the frame and match destination
  assign ip_ok   = (cfg.match_ip == 32'd0) || (item.dest_ip == cfg.match_ip);
  assign port_ok = (cfg.match_port == 16'd0) || (item.dest_port == cfg.match_port);
  assign qual = (item.func == FUNC_FRAME) &&
                (item.pkt_len >= MIN_FRAME_LEN) &&
                (item.ethertype == ETH_TYPE_IPV4) &&
                (item.ip_hdr_words == IP_IHL_PLAIN) &&
                (item.ip_proto == IP_PROTO_UDP) &&
                (cfg.mode != MODE_OFF) && ip_ok && port_ok;

  // Choose rewrites
  assign rw_ip   = qual && (cfg.mode == MODE_REDIRECT);
  assign rw_port = rw_ip || (qual && (cfg.mode == MODE_RW_PORT) && (cfg.new_port != 16'd0));
  assign rw_ttl  = rw_ip && (cfg.new_ttl != 8'd0) && (cfg.new_ttl != item.ip_ttl);
  assign udp_add = rw_port && (item.udp_sum != 16'd0);
  assign stats   = qual && cfg.stats_en;

  // Complemented old words for the incremental update
  assign ndip_hi   = ~item.dest_ip[31:16];
  assign ndip_lo   = ~item.dest_ip[15:0];
  assign nisum     = ~item.ip_sum;
  assign nusum     = ~item.udp_sum;
  assign nport     = ~item.dest_port;
  assign ttl_word  = ~{item.ip_ttl, item.ip_proto};
  assign nttl_word = {cfg.new_ttl, item.ip_proto};

  assign ip32_terms = ACC_BITS'(ndip_hi) + ACC_BITS'(ndip_lo) +
                      ACC_BITS'(cfg.new_ip[31:16]) + ACC_BITS'(cfg.new_ip[15:0]);
  assign ttl_terms  = ACC_BITS'(ttl_word) + ACC_BITS'(nttl_word);
  assign port_terms = ACC_BITS'(nport) + ACC_BITS'(cfg.new_port);

  // Build the classified record
  always_comb begin
    cls.rd        = (item.func == FUNC_READ);
    cls.cidx      = item.counter_index;
    cls.matched   = qual;
    cls.out_ip    = rw_ip ? cfg.new_ip : item.dest_ip;
    cls.out_port  = rw_port ? cfg.new_port : item.dest_port;
    cls.out_ttl   = rw_ttl ? cfg.new_ttl : item.ip_ttl;
    cls.pkt_len   = item.pkt_len;
    cls.udp_map   = udp_add;

    cls.ip_acc = ACC_BITS'(nisum);
    if (rw_ip) begin
      cls.ip_acc = cls.ip_acc + ip32_terms;
    end
    if (rw_ttl) begin
      cls.ip_acc = cls.ip_acc + ttl_terms;
    end

    cls.udp_acc = ACC_BITS'(nusum);
    if (udp_add && rw_ip) begin
      cls.udp_acc = cls.udp_acc + ip32_terms;
    end
    if (udp_add) begin
      cls.udp_acc = cls.udp_acc + port_terms;
    end

    if (rw_ip) begin
      cls.verdict = VERDICT_REDIRECT;
    end else if (qual && (cfg.mode == MODE_DROP)) begin
      cls.verdict = VERDICT_DROP;
    end else begin
      cls.verdict = VERDICT_PASS;
    end

    cls.inc.matched  = stats;
    cls.inc.redirect = stats && (cfg.mode == MODE_REDIRECT);
    cls.inc.drop     = stats && (cfg.mode == MODE_DROP);
    cls.inc.pass     = stats && ((cfg.mode == MODE_PASS) ||
                       ((cfg.mode == MODE_RW_PORT) && (cfg.new_port != 16'd0)));
  end

endmodule

>>> rtl/umrc_back.sv
// Back end: folds the checksum sums, updates and reads the statistics
// counters and forms the result. Depends on umrc_pkg.
module umrc_back
  import umrc_pkg::*;
#(
  parameter int COUNTER_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cls_t      cls,
  input  logic      fire,
  output out_item_t res
);

  logic [COUNTER_BITS-1:0] cnt [NUM_COUNTERS];
  logic [16:0]             ip_f1;
  logic [15:0]             ip_f2;
  logic [16:0]             udp_f1;
  logic [15:0]             udp_f2;
  logic [15:0]             udp_new;

  // Fold the end-around carries twice, then complement
  assign ip_f1  = {1'b0, cls.ip_acc[15:0]} + 17'(cls.ip_acc[ACC_BITS-1:16]);
  assign ip_f2  = ip_f1[15:0] + 16'(ip_f1[16]);
  assign udp_f1 = {1'b0, cls.udp_acc[15:0]} + 17'(cls.udp_acc[ACC_BITS-1:16]);
  assign udp_f2 = udp_f1[15:0] + 16'(udp_f1[16]);
  assign udp_new = (cls.udp_map && (udp_f2 == 16'hffff)) ? 16'hffff : ~udp_f2;

  // Form the result; a counter read zeroes all header fields
  always_comb begin
    res = '0;
    if (cls.rd) begin
      if (cls.cidx < 3'(NUM_COUNTERS)) begin
        res.counter_value = 64'(cnt[cls.cidx]);
      end
    end else begin
      res.verdict     = cls.verdict;
      res.matched     = cls.matched;
      res.out_ip      = cls.out_ip;
      res.out_port    = cls.out_port;
      res.out_ttl     = cls.out_ttl;
      res.out_ip_sum  = ~ip_f2;
      res.out_udp_sum = udp_new;
    end
  end

  // Advance the statistics counters as each item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt[i] <= '0;
      end
    end else if (fire) begin
      if (cls.inc.matched) begin
        cnt[CNT_MATCHED] <= cnt[CNT_MATCHED] + COUNTER_BITS'(1);
        cnt[CNT_BYTES]   <= cnt[CNT_BYTES] + COUNTER_BITS'(cls.pkt_len);
      end
      if (cls.inc.redirect) begin
        cnt[CNT_REDIRECT] <= cnt[CNT_REDIRECT] + COUNTER_BITS'(1);
      end
      if (cls.inc.pass) begin
        cnt[CNT_PASS] <= cnt[CNT_PASS] + COUNTER_BITS'(1);
      end
      if (cls.inc.drop) begin
        cnt[CNT_DROP] <= cnt[CNT_DROP] + COUNTER_BITS'(1);
      end
    end
  end

endmodule

>>> rtl/udp_match_rewrite_checksum_top.sv
// Top level: config registers, front classifier, two-entry queues and back end.
// Depends on umrc_pkg, umrc_fifo, umrc_front and umrc_back.
//
//   channel   handshake                 payload      accepted when
//   item      push / full               in_item_t    push && !full
//   result    pop / empty               out_item_t   pop && !empty
//   config    psel penable pwrite ...   pwdata 32b   psel && penable && pwrite
//
// One item per cycle sustained while the result side pops. The classify
// queue registers the front's record, then the back end folds the
// checksums and updates counters into the result queue. Reset clears the
// registers, the counters and both queues. A stalled result side fills
// the result queue, then the classify queue, then raises full.
module udp_match_rewrite_checksum_top
  import umrc_pkg::*;
#(
  parameter int COUNTER_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  in_item_t             item,
  output logic                 full,
  input  logic                 pop,
  output out_item_t            result,
  output logic                 empty,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t      cfg;
  cls_t      cls_in;
  cls_t      cls_head;
  logic      cls_empty;
  logic      res_full;
  logic      fire;
  logic      cfg_wr;
  out_item_t res_in;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (paddr[ADDR_BITS-1:2])
        REG_MODE:       cfg.mode       <= pwdata[2:0];
        REG_COLLECT:    cfg.stats_en   <= pwdata[0];
        REG_MATCH_IP:   cfg.match_ip   <= pwdata;
        REG_MATCH_PORT: cfg.match_port <= pwdata[15:0];
        REG_NEW_IP:     cfg.new_ip     <= pwdata;
        REG_NEW_PORT:   cfg.new_port   <= pwdata[15:0];
        REG_NEW_TTL:    cfg.new_ttl    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the configuration registers
  always_comb begin
    case (paddr[ADDR_BITS-1:2])
      REG_MODE:       prdata = 32'(cfg.mode);
      REG_COLLECT:    prdata = 32'(cfg.stats_en);
      REG_MATCH_IP:   prdata = cfg.match_ip;
      REG_MATCH_PORT: prdata = 32'(cfg.match_port);
      REG_NEW_IP:     prdata = cfg.new_ip;
      REG_NEW_PORT:   prdata = 32'(cfg.new_port);
      REG_NEW_TTL:    prdata = 32'(cfg.new_ttl);
      default:        prdata = 32'd0;
    endcase
  end

  umrc_front u_front (
    .item (item),
    .cfg  (cfg),
    .cls  (cls_in)
  );

  umrc_fifo #(.T(cls_t)) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cls_in),
    .full  (full),
    .pop   (fire),
    .dout  (cls_head),
    .empty (cls_empty)
  );

  // Move one classified item per cycle while the result queue has room
  assign fire = !cls_empty && !res_full;

  umrc_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk  (clk),
    .rst  (rst),
    .cls  (cls_head),
    .fire (fire),
    .res  (res_in)
  );

  umrc_fifo #(.T(out_item_t)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fire),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

  // An accepted item is waiting in the classify queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> !cls_empty)
    else $error("accepted item missing from classify queue");

  // A counter read result carries no verdict and no match
  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && (result.counter_value != 64'd0) |->
      (result.verdict == VERDICT_PASS) && !result.matched)
    else $error("counter read result carries frame fields");

  // Redirect and drop verdicts only come from matched frames
  a_verdict_matched: assert property (@(posedge clk) disable iff (rst)
    !empty && ((result.verdict == VERDICT_REDIRECT) ||
               (result.verdict == VERDICT_DROP)) |-> result.matched)
    else $error("verdict on unmatched frame");

endmodule

>>> verif/udp_match_rewrite_checksum_top_tb.sv
// Self-checking testbench for the UDP match, rewrite and checksum top level.
// Drives header beats and APB writes, predicts every result beat in-house.
// Depends on umrc_pkg and udp_match_rewrite_checksum_top.
`timescale 1ns / 1ps

module udp_match_rewrite_checksum_top_tb;
  import umrc_pkg::*;

  // Mode codes the block treats as matched pass-through
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  localparam int PHASES          = 12;
  localparam int BEATS_PER_PHASE = 75;
  localparam int LIMIT_CYCLES    = 600000;
  localparam int MAX_REPORTS     = 10;

  localparam logic [2:0] PHASE_MODES [PHASES] = '{
    MODE_PASS, MODE_DROP, MODE_RW_PORT, MODE_REDIRECT, MODE_RW_PORT, MODE_REDIRECT,
    MODE_UNUSED_FIRST, MODE_OFF, MODE_REDIRECT, MODE_UNUSED_LAST, MODE_RW_PORT, MODE_PASS
  };

  typedef enum {CHECK_MODEL, CHECK_ZERO, CHECK_COPY} check_e;
  typedef enum {ROW_WRITE, ROW_BEAT} row_e;

  typedef struct {
    row_e       kind;
    logic [2:0] reg_idx;
    logic [31:0] value;
    in_item_t   beat;
    check_e     how;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  in_item_t             item = '0;
  logic                 full;
  logic                 pop = 1'b0;
  out_item_t            result;
  logic                 empty;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Shadow of the block's registers and counters
  cfg_t        shadow_cfg = '0;
  logic [63:0] stat_tally [NUM_COUNTERS];

  out_item_t   pending_results [$];
  plan_row_t   directed_plan [$];

  int unsigned mismatches = 0;
  int unsigned n_checked = 0;
  int unsigned n_frames = 0;
  int unsigned n_reads = 0;
  int unsigned n_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  logic        steady = 1'b0;
  out_item_t   want;

  udp_match_rewrite_checksum_top #(.COUNTER_BITS(64)) uut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .result(result), .empty(empty),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Ones' complement helpers: fold the carries back in, then invert
  function automatic logic [15:0] fold_inv(logic [31:0] acc);
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  function automatic logic [15:0] patch16(logic [15:0] check, logic [15:0] old_w,
                                          logic [15:0] new_w);
    return fold_inv({16'h0, ~check} + {16'h0, ~old_w} + {16'h0, new_w});
  endfunction

  function automatic logic [15:0] patch32(logic [15:0] check, logic [31:0] old_w,
                                          logic [31:0] new_w);
    logic [31:0] inv_old;
    inv_old = ~old_w;
    return fold_inv({16'h0, ~check} + {16'h0, inv_old[15:0]} + {16'h0, inv_old[31:16]}
                    + {16'h0, new_w[15:0]} + {16'h0, new_w[31:16]});
  endfunction

  // Classify, rewrite and count one header beat, as the block does
  function automatic out_item_t predict_rewrite(in_item_t b);
    out_item_t   r;
    logic [31:0] dip;
    logic [15:0] dport;
    logic [15:0] isum;
    logic [15:0] usum;
    logic [7:0]  ttl;
    logic        stats;
    r = '0;
    if (b.func == FUNC_READ) begin
      if (b.counter_index < NUM_COUNTERS) r.counter_value = stat_tally[b.counter_index];
      return r;
    end
    dip = b.dest_ip;
    dport = b.dest_port;
    isum = b.ip_sum;
    usum = b.udp_sum;
    ttl = b.ip_ttl;
    if (b.pkt_len >= MIN_FRAME_LEN && b.ethertype == ETH_TYPE_IPV4 &&
        b.ip_hdr_words == IP_IHL_PLAIN && b.ip_proto == IP_PROTO_UDP &&
        shadow_cfg.mode != MODE_OFF &&
        (shadow_cfg.match_ip == '0 || dip == shadow_cfg.match_ip) &&
        (shadow_cfg.match_port == '0 || dport == shadow_cfg.match_port)) begin
      r.matched = 1'b1;
      stats = shadow_cfg.stats_en;
      if (stats) begin
        stat_tally[CNT_MATCHED] += 64'd1;
        stat_tally[CNT_BYTES] += {48'h0, b.pkt_len};
      end
      case (shadow_cfg.mode)
        MODE_REDIRECT: begin
          isum = patch32(isum, dip, shadow_cfg.new_ip);
          if (shadow_cfg.new_ttl != '0 && shadow_cfg.new_ttl != ttl) begin
            isum = patch16(isum, {ttl, b.ip_proto}, {shadow_cfg.new_ttl, b.ip_proto});
            ttl = shadow_cfg.new_ttl;
          end
          if (usum != '0) begin
            usum = patch32(usum, dip, shadow_cfg.new_ip);
            usum = patch16(usum, dport, shadow_cfg.new_port);
            if (usum == '0) usum = 16'hffff;
          end
          dip = shadow_cfg.new_ip;
          dport = shadow_cfg.new_port;
          if (stats) stat_tally[CNT_REDIRECT] += 64'd1;
          r.verdict = VERDICT_REDIRECT;
        end
        MODE_RW_PORT: begin
          if (shadow_cfg.new_port != '0) begin
            if (usum != '0) begin
              usum = patch16(usum, dport, shadow_cfg.new_port);
              if (usum == '0) usum = 16'hffff;
            end
            dport = shadow_cfg.new_port;
            if (stats) stat_tally[CNT_PASS] += 64'd1;
          end
        end
        MODE_DROP: begin
          if (stats) stat_tally[CNT_DROP] += 64'd1;
          r.verdict = VERDICT_DROP;
        end
        MODE_PASS: begin
          if (stats) stat_tally[CNT_PASS] += 64'd1;
        end
        default: ;
      endcase
    end
    r.out_ip = dip;
    r.out_port = dport;
    r.out_ttl = ttl;
    r.out_ip_sum = isum;
    r.out_udp_sum = usum;
    return r;
  endfunction

  // Idle lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Zero, all ones or random, at the given width
  function automatic logic [31:0] pick_value(int unsigned bits);
    logic [31:0] mask;
    mask = (bits == 32) ? 32'hffffffff : ((32'd1 << bits) - 32'd1);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic in_item_t mk_frame(logic [15:0] len, logic [7:0] ttl, logic [31:0] dip,
                                        logic [15:0] dport, logic [15:0] usum);
    in_item_t b;
    b = '0;
    b.func = FUNC_FRAME;
    b.pkt_len = len;
    b.ethertype = ETH_TYPE_IPV4;
    b.ip_hdr_words = IP_IHL_PLAIN;
    b.ip_proto = IP_PROTO_UDP;
    b.ip_ttl = ttl;
    b.dest_ip = dip;
    b.ip_sum = 16'($urandom);
    b.dest_port = dport;
    b.udp_sum = usum;
    return b;
  endfunction

  // Random beat: noise, counter reads, broken headers, mostly well-formed frames
  function automatic in_item_t random_beat();
    in_item_t    b;
    int unsigned r;
    int unsigned pick;
    r = $urandom_range(0, 99);
    b.func = FUNC_FRAME;
    b.pkt_len = 16'($urandom);
    b.ethertype = 16'($urandom);
    b.ip_hdr_words = 4'($urandom);
    b.ip_proto = 8'($urandom);
    b.ip_ttl = 8'($urandom);
    b.dest_ip = $urandom;
    b.ip_sum = 16'($urandom);
    b.dest_port = 16'($urandom);
    b.udp_sum = 16'($urandom);
    b.counter_index = 3'($urandom);
    if (r < 10) return b;
    if (r < 20) begin
      b.func = FUNC_READ;
      return b;
    end
    b.pkt_len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(42, 65535))
                                            : 16'($urandom_range(42, 1518));
    b.ethertype = ETH_TYPE_IPV4;
    b.ip_hdr_words = IP_IHL_PLAIN;
    b.ip_proto = IP_PROTO_UDP;
    if ($urandom_range(0, 4) == 0) b.ip_ttl = shadow_cfg.new_ttl;
    pick = $urandom_range(0, 19);
    if (pick < 14 && shadow_cfg.match_ip != '0) b.dest_ip = shadow_cfg.match_ip;
    else if (pick >= 14 && pick < 16) b.dest_ip = shadow_cfg.new_ip;
    pick = $urandom_range(0, 19);
    if (pick < 14 && shadow_cfg.match_port != '0) b.dest_port = shadow_cfg.match_port;
    else if (pick >= 14 && pick < 16) b.dest_port = shadow_cfg.new_port;
    pick = $urandom_range(0, 19);
    if (pick < 3) b.udp_sum = '0;
    else if (pick < 4) b.udp_sum = 16'hffff;
    // Break at most one qualifying check
    if (r < 32) begin
      case ($urandom_range(0, 5))
        0: b.pkt_len = 16'($urandom_range(0, 41));
        1: b.ethertype = ETH_TYPE_IPV4 ^ 16'($urandom_range(1, 65535));
        2: b.ip_hdr_words = IP_IHL_PLAIN ^ 4'($urandom_range(1, 15));
        3: b.ip_proto = IP_PROTO_UDP ^ 8'($urandom_range(1, 255));
        4: b.dest_ip = shadow_cfg.match_ip ^ 32'($urandom_range(1, 65535));
        default: b.dest_port = shadow_cfg.match_port ^ 16'($urandom_range(1, 65535));
      endcase
    end
    return b;
  endfunction

  task automatic add_write(logic [2:0] idx, logic [31:0] v);
    plan_row_t row;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.value = v;
    row.beat = '0;
    row.how = CHECK_MODEL;
    directed_plan.push_back(row);
  endtask

  task automatic add_beat(in_item_t b, check_e how);
    plan_row_t row;
    row.kind = ROW_BEAT;
    row.reg_idx = REG_MODE;
    row.value = '0;
    row.beat = b;
    row.how = how;
    directed_plan.push_back(row);
  endtask

  // APB write: setup, access, then idle with the bus released
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:       shadow_cfg.mode = v[2:0];
      REG_COLLECT:    shadow_cfg.stats_en = v[0];
      REG_MATCH_IP:   shadow_cfg.match_ip = v;
      REG_MATCH_PORT: shadow_cfg.match_port = v[15:0];
      REG_NEW_IP:     shadow_cfg.new_ip = v;
      REG_NEW_PORT:   shadow_cfg.new_port = v[15:0];
      REG_NEW_TTL:    shadow_cfg.new_ttl = v[7:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  // Hold push low until every expected result beat is back
  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one beat, at times after a random gap, record its expected result on acceptance
  task automatic send_beat(in_item_t b, check_e how);
    int unsigned gap;
    out_item_t   model;
    out_item_t   typed;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= b;
    do @(posedge clk); while (full);
    model = predict_rewrite(b);
    typed = '0;
    case (how)
      CHECK_ZERO: pending_results.push_back(typed);
      CHECK_COPY: begin
        typed.verdict = VERDICT_PASS;
        typed.out_ip = b.dest_ip;
        typed.out_port = b.dest_port;
        typed.out_ttl = b.ip_ttl;
        typed.out_ip_sum = b.ip_sum;
        typed.out_udp_sum = b.udp_sum;
        pending_results.push_back(typed);
      end
      default: pending_results.push_back(model);
    endcase
    if (b.func == FUNC_READ) n_reads++;
    else n_frames++;
  endtask

  task automatic check_beat(out_item_t got, out_item_t exp_r);
    if (got.verdict !== exp_r.verdict || got.matched !== exp_r.matched ||
        got.out_ip !== exp_r.out_ip || got.out_port !== exp_r.out_port ||
        got.out_ttl !== exp_r.out_ttl || got.out_ip_sum !== exp_r.out_ip_sum ||
        got.out_udp_sum !== exp_r.out_udp_sum || got.counter_value !== exp_r.counter_value)
    begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("result %0d mismatch: verdict %0d/%0d matched %0d/%0d ip %h/%h port %h/%h",
                 n_checked, exp_r.verdict, got.verdict, exp_r.matched, got.matched,
                 exp_r.out_ip, got.out_ip, exp_r.out_port, got.out_port);
        $display("  ttl %h/%h ip_sum %h/%h udp_sum %h/%h counter %h/%h (expected/actual)",
                 exp_r.out_ttl, got.out_ttl, exp_r.out_ip_sum, got.out_ip_sum,
                 exp_r.out_udp_sum, got.out_udp_sum, exp_r.counter_value, got.counter_value);
      end
    end
  endtask

  // Switch between stretches with and without idling
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) steady <= ~steady;
  end

  // Result side: check each accepted beat, stall pop at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) $display("result beat with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_beat(result, want);
        end
        n_checked++;
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("udp_match_rewrite_checksum_top_tb failed");
      $finish;
    end
  end

  initial begin
    in_item_t b;
    foreach (stat_tally[i]) stat_tally[i] = '0;

    // Counter reads after reset, including an out-of-range index
    b = '0;
    b.func = FUNC_READ;
    b.counter_index = CNT_MATCHED;
    add_beat(b, CHECK_ZERO);
    b = '1;
    b.func = FUNC_READ;
    add_beat(b, CHECK_ZERO);
    // Disabled block copies the header
    add_beat(mk_frame(MIN_FRAME_LEN, 8'd64, 32'h0a000001, 16'd53, 16'h1234), CHECK_COPY);

    add_write(REG_COLLECT, 32'd1);
    add_write(REG_MODE, {29'h0, MODE_PASS});
    add_beat(mk_frame(MIN_FRAME_LEN, 8'd1, 32'h0, 16'h0, 16'h0), CHECK_MODEL);
    // Each qualifying check broken on its own
    add_beat(mk_frame(MIN_FRAME_LEN - 16'd1, 8'd64, 32'h01020304, 16'd7, 16'h55aa),
             CHECK_COPY);
    b = mk_frame(16'd100, 8'd64, 32'h01020304, 16'd7, 16'h55aa);
    b.ethertype = 16'h86dd;
    add_beat(b, CHECK_COPY);
    b = mk_frame(16'd100, 8'd64, 32'h01020304, 16'd7, 16'h55aa);
    b.ip_hdr_words = 4'hf;
    add_beat(b, CHECK_COPY);
    b = mk_frame(16'd100, 8'd64, 32'h01020304, 16'd7, 16'h55aa);
    b.ip_proto = 8'd6;
    add_beat(b, CHECK_COPY);
    add_beat(mk_frame(16'hffff, 8'hff, 32'hffffffff, 16'hffff, 16'hffff), CHECK_MODEL);

    add_write(REG_MODE, {29'h0, MODE_DROP});
    add_beat(mk_frame(16'd60, 8'd10, 32'hc0000201, 16'd80, 16'habcd), CHECK_MODEL);

    // Port rewrite: folded zero maps to all ones, absent checksum stays zero
    add_write(REG_NEW_PORT, 32'h1234);
    add_write(REG_MODE, {29'h0, MODE_RW_PORT});
    add_beat(mk_frame(16'd64, 8'd20, 32'h0a0a0a0a, 16'h1234, 16'hffff), CHECK_MODEL);
    add_beat(mk_frame(16'd64, 8'd20, 32'h0a0a0a0a, 16'h4321, 16'h0000), CHECK_MODEL);
    add_write(REG_NEW_PORT, 32'h0);
    add_beat(mk_frame(16'd64, 8'd20, 32'h0a0a0a0a, 16'h4321, 16'h9876), CHECK_MODEL);

    // Redirect with exact match on IP and port
    add_write(REG_MATCH_IP, 32'h0a000001);
    add_write(REG_MATCH_PORT, 32'd53);
    add_write(REG_NEW_IP, 32'hc0a80001);
    add_write(REG_NEW_PORT, 32'h2000);
    add_write(REG_NEW_TTL, 32'd64);
    add_write(REG_MODE, {29'h0, MODE_REDIRECT});
    add_beat(mk_frame(16'd90, 8'd64, 32'h0a000001, 16'd53, 16'h7777), CHECK_MODEL);
    add_beat(mk_frame(16'd90, 8'd1, 32'h0a000001, 16'd53, 16'h7777), CHECK_MODEL);
    add_beat(mk_frame(16'd90, 8'd1, 32'h0a000002, 16'd53, 16'h7777), CHECK_COPY);
    add_beat(mk_frame(16'd90, 8'd1, 32'h0a000001, 16'd54, 16'h7777), CHECK_COPY);
    add_write(REG_NEW_TTL, 32'd0);
    add_beat(mk_frame(16'd90, 8'd1, 32'h0a000001, 16'd53, 16'h0000), CHECK_MODEL);
    add_write(REG_MODE, {29'h0, MODE_UNUSED_LAST});
    add_beat(mk_frame(16'd90, 8'd1, 32'h0a000001, 16'd53, 16'h7777), CHECK_MODEL);
    // Read back every counter
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      b = '0;
      b.func = FUNC_READ;
      b.counter_index = 3'(i);
      add_beat(b, CHECK_MODEL);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
      end else begin
        send_beat(directed_plan[i].beat, directed_plan[i].how);
      end
    end

    // Random phases, each under a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_MATCH_IP, pick_value(32));
      write_reg(REG_MATCH_PORT, pick_value(16));
      write_reg(REG_NEW_IP, pick_value(32));
      write_reg(REG_NEW_PORT, pick_value(16));
      write_reg(REG_NEW_TTL, pick_value(8));
      write_reg(REG_COLLECT, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
      write_reg(REG_MODE, {29'h0, PHASE_MODES[p]});
      for (int k = 0; k < BEATS_PER_PHASE; k++) send_beat(random_beat(), CHECK_MODEL);
    end

    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      $display("%0d expected result beats never arrived", pending_results.size());
    $display("Covered %0d frame beats and %0d counter reads over %0d register writes,",
             n_frames, n_reads, n_writes);
    $display("every mode code and random idling on both sides; %0d result beats compared.",
             n_checked);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("udp_match_rewrite_checksum_top_tb passed");
    end else begin
      $display("udp_match_rewrite_checksum_top_tb failed");
    end
    $finish;
  end

endmodule
